// File: design/fp32_affine_quantizer_macros.svh
// Assertion macros for the fp32 affine quantizer.
// Used by modules that include this header; expects clk_i and rst_ni in scope.
`ifndef FP32_AFFINE_QUANTIZER_MACROS_SVH
`define FP32_AFFINE_QUANTIZER_MACROS_SVH

// same-cycle implication
`define FPAQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/fpaq_pkg.sv
// Package for the fp32 affine quantizer: item types, stage structs, codes,
// rounding and clamp helpers. No dependencies.
package fpaq_pkg;

  typedef struct packed {
    logic [31:0] value_bits;
    logic        last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] quantized;
    logic               last_out;
  } out_item_t;

  typedef enum logic [2:0] {
    OT_INT8   = 3'd0,
    OT_UINT8  = 3'd1,
    OT_INT16  = 3'd2,
    OT_UINT16 = 3'd3,
    OT_INT32  = 3'd4
  } out_type_e;

  localparam logic [1:0] CFG_SCALE    = 2'd0;
  localparam logic [1:0] CFG_ZERO_OFS = 2'd1;
  localparam logic [1:0] CFG_OUT_TYPE = 2'd2;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

  // exact product of the two significands
  typedef struct packed {
    logic [47:0]        man;
    logic signed [9:0]  exp;
    logic               neg;
    logic               zero;
    logic               big;
    logic               last;
  } prod_t;

  // product rounded to fp32: value = r * 2^q
  typedef struct packed {
    logic [23:0]        r;
    logic signed [10:0] q;
    logic               neg;
    logic               zero;
    logic               big;
    logic               last;
  } rnd_t;

  typedef struct packed {
    logic signed [42:0] lo;
    logic signed [42:0] hi;
  } bounds_t;

  // m >> s with round half to even, s in 1..48
  function automatic logic [24:0] rne_shr(input logic [47:0] m, input logic [5:0] s);
    logic [47:0] qv;
    logic [47:0] mask;
    logic [47:0] rem;
    logic [47:0] half;
    qv   = m >> s;
    mask = (48'd1 << s) - 48'd1;
    rem  = m & mask;
    half = 48'd1 << (s - 6'd1);
    if (rem > half || (rem == half && qv[0])) begin
      qv = qv + 48'd1;
    end
    return qv[24:0];
  endfunction

  function automatic bounds_t type_bounds(input logic [2:0] ot);
    bounds_t b;
    unique case (ot)
      OT_INT8: begin
        b.lo = -43'sd128;
        b.hi = 43'sd127;
      end
      OT_UINT8: begin
        b.lo = 43'sd0;
        b.hi = 43'sd255;
      end
      OT_INT16: begin
        b.lo = -43'sd32768;
        b.hi = 43'sd32767;
      end
      OT_UINT16: begin
        b.lo = 43'sd0;
        b.hi = 43'sd65535;
      end
      default: begin
        b.lo = -43'sd2147483648;
        b.hi = 43'sd2147483647;
      end
    endcase
    return b;
  endfunction

endpackage

// File: design/fpaq_mul.sv
// Unpack and significand multiply stage of the quantizer.
// Depends on fpaq_pkg; registers the exact product and special-case flags.
module fpaq_mul import fpaq_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  in_item_t    item_i,
  input  logic [31:0] scale_i,
  output prod_t       prod_o
);

  logic [7:0]        ea_raw, eb_raw;
  logic [22:0]       fa, fb;
  logic [23:0]       ma, mb;
  logic signed [9:0] ea, eb;
  logic              nan_a, nan_b, inf_a, inf_b;
  logic [47:0]       m;
  prod_t             prod_d, prod_q;

  always_comb begin
    ea_raw = item_i.value_bits[30:23];
    eb_raw = scale_i[30:23];
    fa     = item_i.value_bits[22:0];
    fb     = scale_i[22:0];
    nan_a  = (ea_raw == 8'hFF) && (fa != 23'd0);
    nan_b  = (eb_raw == 8'hFF) && (fb != 23'd0);
    inf_a  = (ea_raw == 8'hFF) && (fa == 23'd0);
    inf_b  = (eb_raw == 8'hFF) && (fb == 23'd0);
    ma     = (ea_raw == 8'd0) ? {1'b0, fa} : {1'b1, fa};
    mb     = (eb_raw == 8'd0) ? {1'b0, fb} : {1'b1, fb};
    ea     = (ea_raw == 8'd0) ? -10'sd149 : $signed({2'b00, ea_raw}) - 10'sd150;
    eb     = (eb_raw == 8'd0) ? -10'sd149 : $signed({2'b00, eb_raw}) - 10'sd150;
    m      = ma * mb;

    prod_d.man  = m;
    prod_d.exp  = ea + eb;
    prod_d.neg  = item_i.value_bits[31] ^ scale_i[31];
    prod_d.last = item_i.last_in;
    prod_d.big  = 1'b0;
    prod_d.zero = 1'b0;
    if (nan_a || nan_b) begin
      prod_d.zero = 1'b1;
    end else if (inf_a || inf_b) begin
      if ((!inf_a && ma == 24'd0) || (!inf_b && mb == 24'd0)) begin
        prod_d.zero = 1'b1;
      end else begin
        prod_d.big = 1'b1;
      end
    end else if (m == 48'd0) begin
      prod_d.zero = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

// File: design/fpaq_round.sv
// Normalize and round the exact product to fp32 (ties to even, subnormals kept).
// Depends on fpaq_pkg; registers significand r and exponent q.
module fpaq_round import fpaq_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  prod_t prod_i,
  output rnd_t  rnd_o
);

  logic [5:0]         p;
  logic signed [10:0] q, s;
  logic [24:0]        r;
  logic [10:0]        ls;
  rnd_t               rnd_d, rnd_q;

  always_comb begin
    p = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (prod_i.man[i]) begin
        p = 6'(i);
      end
    end
    q = $signed({5'd0, p}) + 11'(prod_i.exp) - 11'sd23;
    if (q < -11'sd149) begin
      q = -11'sd149;
    end
    s  = q - 11'(prod_i.exp);
    ls = 11'(-s);
    if (s <= 11'sd0) begin
      r = 25'(prod_i.man << ls[4:0]);
    end else if (s >= 11'sd49) begin
      r = 25'd0;
    end else begin
      r = rne_shr(prod_i.man, s[5:0]);
    end
    if (r[24]) begin
      r = r >> 1;
      q = q + 11'sd1;
    end
    rnd_d.r    = r[23:0];
    rnd_d.q    = q;
    rnd_d.neg  = prod_i.neg;
    rnd_d.big  = prod_i.big;
    rnd_d.zero = prod_i.zero || (r == 25'd0);
    rnd_d.last = prod_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rnd_q <= rnd_d;
    end
  end

  assign rnd_o = rnd_q;

endmodule

// File: design/fpaq_clamp.sv
// Round to integer (ties to even), add zero point, clamp to the output type.
// Depends on fpaq_pkg; holds the result register.
module fpaq_clamp import fpaq_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  rnd_t               rnd_i,
  input  logic signed [31:0] zero_ofs_i,
  input  logic [2:0]         out_type_i,
  output out_item_t          item_o
);

  logic [40:0]        mag;
  logic [10:0]        k;
  logic signed [42:0] v, sum;
  logic               sat;
  bounds_t            b;
  out_item_t          item_d, item_q;

  always_comb begin
    k   = 11'(-rnd_i.q);
    sat = rnd_i.big || (!rnd_i.zero && rnd_i.q > 11'sd16);
    if (rnd_i.zero || rnd_i.big) begin
      mag = 41'd0;
    end else if (rnd_i.q >= 11'sd0) begin
      mag = {17'd0, rnd_i.r} << rnd_i.q[4:0];
    end else if (k >= 11'd25) begin
      mag = 41'd0;
    end else begin
      mag = {16'd0, rne_shr({24'd0, rnd_i.r}, k[5:0])};
    end
    v   = rnd_i.neg ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    sum = v + 43'(zero_ofs_i);
    b   = type_bounds(out_type_i);
    if (sat) begin
      sum = rnd_i.neg ? b.lo : b.hi;
    end else if (sum < b.lo) begin
      sum = b.lo;
    end else if (sum > b.hi) begin
      sum = b.hi;
    end
    item_d.quantized = sum[31:0];
    item_d.last_out  = rnd_i.last;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// File: design/fp32_affine_quantizer.sv
// fp32 affine quantizer: one item per clock while the output is not stalled. Each item passes four
// registers (input, significand product, fp32-rounded product, result); the 24x24
// significand multiply sets the stage split. A stall on the output backs up the
// stages in turn and reaches the input only when all four are full.
// Depends on fpaq_pkg, fpaq_mul, fpaq_round, fpaq_clamp and the macros header.
`include "fp32_affine_quantizer_macros.svh"
module fp32_affine_quantizer import fpaq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o
);

  logic [31:0]        scale_q;
  logic signed [31:0] zero_ofs_q;
  logic [2:0]         out_type_q;
  logic               v1_q, v2_q, v3_q, vo_q;
  logic               en1, en2, en3, eno;
  in_item_t           in_q;
  prod_t              prod;
  rnd_t               rnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q    <= SCALE_RESET;
      zero_ofs_q <= '0;
      out_type_q <= OT_INT8;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCALE:    scale_q    <= cfg_wdata_i;
        CFG_ZERO_OFS: zero_ofs_q <= cfg_wdata_i;
        CFG_OUT_TYPE: out_type_q <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  assign eno        = !vo_q || !out_stall_i;
  assign en3        = !v3_q || eno;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (eno) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      in_q <= in_item_i;
    end
  end

  fpaq_mul u_mul (
    .clk_i   (clk_i),
    .en_i    (en2),
    .item_i  (in_q),
    .scale_i (scale_q),
    .prod_o  (prod)
  );

  fpaq_round u_round (
    .clk_i  (clk_i),
    .en_i   (en3),
    .prod_i (prod),
    .rnd_o  (rnd)
  );

  fpaq_clamp u_clamp (
    .clk_i      (clk_i),
    .en_i       (eno),
    .rnd_i      (rnd),
    .zero_ofs_i (zero_ofs_q),
    .out_type_i (out_type_q),
    .item_o     (out_item_o)
  );

  assign out_valid_o = vo_q;

  `FPAQ_ASSERT_NOW(a_stall_full, in_stall_o, v1_q && v2_q && v3_q && vo_q, "input stalled with a free stage")
  `FPAQ_ASSERT_NOW(a_int8_range, vo_q && out_type_q == OT_INT8, $signed(out_item_o.quantized) >= -32'sd128 && $signed(out_item_o.quantized) <= 32'sd127, "int8 result out of range")
  `FPAQ_ASSERT_NEXT(a_drain, v3_q && !vo_q, vo_q, "finished item not moved to output")

endmodule

// File: tb/tb_fp32_affine_quantizer.sv
// Testbench for fp32_affine_quantizer: random and directed fp32 items under
// several scale, zero point and output-type settings, checked by a scoreboard.
// Depends on fpaq_pkg and the RTL of the block.
module tb_fp32_affine_quantizer import fpaq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint BIG_MAG = 64'sd1 << 41;

  class quant_scoreboard;
    logic [31:0] scale;
    int          zero_ofs;
    logic [2:0]  otype;
    out_item_t   pending_q[$];
    int          errors;

    function new();
      scale    = SCALE_RESET;
      zero_ofs = 0;
      otype    = OT_INT8;
      errors   = 0;
    endfunction

    static function longint unsigned rne_shift(longint unsigned m, int s);
      longint unsigned q, rem, half;
      if (s <= 0) return m << (-s);
      if (s >= 50) return 0;
      q = m >> s;
      rem = m & ((64'd1 << s) - 1);
      half = 64'd1 << (s - 1);
      if (rem > half || (rem == half && q[0])) q++;
      return q;
    endfunction

    // rounded integer of fp32(a*b); NaN gives 0, overflow gives +-BIG_MAG
    static function longint scaled_int(logic [31:0] a, logic [31:0] b);
      longint unsigned ma, mb, m, r, mag;
      int ea, eb, e, p, q;
      bit neg, nan_a, nan_b, inf_a, inf_b;
      neg = a[31] ^ b[31];
      nan_a = (a[30:23] == 8'hFF) && (a[22:0] != 0);
      nan_b = (b[30:23] == 8'hFF) && (b[22:0] != 0);
      inf_a = (a[30:23] == 8'hFF) && (a[22:0] == 0);
      inf_b = (b[30:23] == 8'hFF) && (b[22:0] == 0);
      if (nan_a || nan_b) return 0;
      ma = (a[30:23] == 0) ? {41'd0, a[22:0]} : {40'd0, 1'b1, a[22:0]};
      mb = (b[30:23] == 0) ? {41'd0, b[22:0]} : {40'd0, 1'b1, b[22:0]};
      if (inf_a || inf_b) begin
        if ((!inf_a && ma == 0) || (!inf_b && mb == 0)) return 0;
        return neg ? -BIG_MAG : BIG_MAG;
      end
      ea = (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
      eb = (b[30:23] == 0) ? -149 : int'(b[30:23]) - 150;
      m = ma * mb;
      if (m == 0) return 0;
      e = ea + eb;
      p = 63;
      while (m[p] == 1'b0) p--;
      q = p + e - 23;
      if (q < -149) q = -149;
      r = rne_shift(m, q - e);
      if (r >= (64'd1 << 24)) begin
        r = r >> 1;
        q++;
      end
      if (r == 0) return 0;
      if (q > 16) mag = BIG_MAG;
      else if (q >= 0) mag = r << q;
      else mag = rne_shift(r, -q);
      return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function void note_input(in_item_t it);
      longint v, lo, hi;
      out_item_t exp_item;
      v = scaled_int(scale, it.value_bits) + longint'(zero_ofs);
      case (otype)
        OT_INT8: begin lo = -128; hi = 127; end
        OT_UINT8: begin lo = 0; hi = 255; end
        OT_INT16: begin lo = -32768; hi = 32767; end
        OT_UINT16: begin lo = 0; hi = 65535; end
        default: begin lo = -64'sd2147483648; hi = 64'sd2147483647; end
      endcase
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      exp_item.quantized = v[31:0];
      exp_item.last_out  = it.last_in;
      pending_q.push_back(exp_item);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected item quantized=%0d last=%0b", $time, got.quantized,
                 got.last_out);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.quantized !== want.quantized) begin
        $display("%0t: quantized expected %0d actual %0d", $time, want.quantized,
                 got.quantized);
        errors++;
      end
      if (got.last_out !== want.last_out) begin
        $display("%0t: last_out expected %0b actual %0b", $time, want.last_out,
                 got.last_out);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_SCALE;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;

  quant_scoreboard sb = new();
  int burst_left = 0;

  fp32_affine_quantizer u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_input(in_item_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_item_o);
    end
  end

  // receiver: rotates through four stall patterns, with two long hold-offs
  int rx_cycle = 0;
  int hold_left = 0;
  always @(negedge clk_i) begin
    rx_cycle++;
    if (rx_cycle == 1500 || rx_cycle == 4000) hold_left = 120;
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case ((rx_cycle / 200) % 4)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 9) < 3);
        2: out_stall_i <= ($urandom_range(0, 9) < 7);
        default: out_stall_i <= ((rx_cycle % 5) < 2);
      endcase
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_SCALE: sb.scale = data;
      CFG_ZERO_OFS: sb.zero_ofs = int'(data);
      default: sb.otype = data[2:0];
    endcase
  endtask

  task automatic wait_drained();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic configure(logic [31:0] scale, logic [31:0] zo, logic [2:0] ot);
    wait_drained();
    write_reg(CFG_SCALE, scale);
    write_reg(CFG_ZERO_OFS, zo);
    write_reg(CFG_OUT_TYPE, {29'd0, ot});
  endtask

  task automatic send_item(logic [31:0] bits, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_item_i.value_bits = bits;
    in_item_i.last_in = last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(0, 9))
      0, 1: ;
      7: begin
        case ($urandom_range(0, 4))
          0: v[30:0] = '0;
          1: v[30:0] = {8'hFF, 23'd0};
          2: v[30:23] = 8'hFF;
          default: v[30:23] = 8'h00;
        endcase
      end
      default: v[30:23] = 8'(int'($urandom_range(118, 160)));
    endcase
    return v;
  endfunction

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
  endtask

  logic [31:0] directed[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
    32'hFFFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h0000_0001, 32'h807F_FFFF,
    32'h3F00_0000, 32'h3FC0_0000, 32'h4020_0000, 32'hC020_0000, 32'h42FF_0000,
    32'hC300_8000, 32'h4F00_0000, 32'hCF00_0001, 32'h3EFF_FFFF, 32'h4B7F_FFFF};

  logic [31:0] scales[] = '{SCALE_RESET, 32'h3E00_0000, 32'h4480_0000, 32'h0000_0001,
                            32'h7F7F_FFFF, 32'hFFFF_FFFF, 32'hBF80_0000, 32'h7F80_0000,
                            32'h3CA3_D70A, 32'h3F00_0000};
  logic [31:0] zofs[] = '{32'd0, 32'd3, 32'hFFFF_FF80, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'd100, 32'd0, 32'hFFFF_FFFF, 32'd40000, 32'd128};
  logic [2:0] otypes[] = '{OT_INT8, OT_UINT8, OT_INT16, OT_UINT16, OT_INT32,
                           3'd5, 3'd7, OT_INT32, OT_UINT16, 3'd6};

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    foreach (directed[i]) send_item(directed[i], i[0]);
    stop_sending();
    configure(32'h4100_0000, 32'hFFFF_FFF0, OT_INT32);
    foreach (directed[i]) send_item(directed[i], ~i[0]);
    for (int ph = 0; ph < $size(scales); ph++) begin
      stop_sending();
      configure(scales[ph], zofs[ph], otypes[ph]);
      repeat (150) send_item(rand_value(), $urandom_range(0, 1));
    end
    stop_sending();
    wait_drained();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #3ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
